// ===== design/fss_pkg.sv =====
// ============================================================================
// fss_pkg
// Shared types, codes, score constants and character helpers for the fuzzy
// subsequence scorer.
// ============================================================================
`default_nettype none

package fss_pkg;

  // Request codes carried by in_req_type.
  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_NEEDLE = 2'd1,
    REQ_HAY    = 2'd2,
    REQ_END    = 2'd3
  } req_t;

  // Match kind codes carried by out_match_kind.
  localparam logic [1:0] KIND_NONE     = 2'd0;
  localparam logic [1:0] KIND_EMPTY    = 2'd1;
  localparam logic [1:0] KIND_INITIALS = 2'd2;
  localparam logic [1:0] KIND_FUZZY    = 2'd3;

  localparam int unsigned SCORE_W = 11;

  localparam logic [SCORE_W-1:0] SCORE_EMPTY    = 11'd100;
  localparam logic [SCORE_W-1:0] SCORE_INITIALS = 11'd500;
  localparam logic [SCORE_W-1:0] SCORE_MAX      = 11'd2047;
  localparam logic [SCORE_W-1:0] SCORE_FLOOR    = 11'd1;

  // Per-character fuzzy points.
  localparam logic [4:0] PTS_BASE   = 5'd1;
  localparam logic [4:0] PTS_WORD   = 5'd10;
  localparam logic [4:0] PTS_CONSEC = 5'd5;
  localparam logic [4:0] PTS_FIRST  = 5'd15;

  // Division by ten through a reciprocal: exact for any value below 2**16.
  localparam logic [16:0] DIV10_MUL   = 17'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  typedef struct packed {
    logic               matched;
    logic [SCORE_W-1:0] score;
    logic [1:0]         kind;
    logic               too_long;
  } result_t;

  // Lowercase fold of the ASCII capitals only.
  function automatic logic [7:0] fold(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

  // Space and the 32 punctuation characters that separate words.
  function automatic logic is_boundary(input logic [7:0] c);
    logic b;
    case (c)
      8'h20, 8'h2D, 8'h5F, 8'h2E, 8'h2F, 8'h5C, 8'h28, 8'h29, 8'h5B,
      8'h5D, 8'h7B, 8'h7D, 8'h3A, 8'h3B, 8'h2C, 8'h21, 8'h3F, 8'h40,
      8'h23, 8'h24, 8'h25, 8'h5E, 8'h26, 8'h2A, 8'h2B, 8'h3D, 8'h7C,
      8'h3C, 8'h3E, 8'h22, 8'h27, 8'h60, 8'h7E: b = 1'b1;
      default: b = 1'b0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// ===== design/fss_needle_mem.sv =====
// ============================================================================
// fss_needle_mem
// Needle character store: one write port and two read ports, each read
// registered, with write-first forwarding when a read hits the entry written.
// ============================================================================
`default_nettype none

module fss_needle_mem #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic [AW-1:0] rd0_addr,
  output logic      [7:0]    rd0_data,
  input  wire logic [AW-1:0] rd1_addr,
  output logic      [7:0]    rd1_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd0_r;
  logic [7:0] rd1_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd0_r <= (wr_en && wr_addr == rd0_addr) ? wr_data : mem[rd0_addr];
    rd1_r <= (wr_en && wr_addr == rd1_addr) ? wr_data : mem[rd1_addr];
  end

  assign rd0_data = rd0_r;
  assign rd1_data = rd1_r;

endmodule

`default_nettype wire

// ===== design/fuzzy_subsequence_scorer.sv =====
// ============================================================================
// fuzzy_subsequence_scorer
// Scores a stored needle against a streamed haystack by initials match or
// greedy case-insensitive subsequence match, one result per end marker.
// ============================================================================
//
//   Channel  Ports                               Direction  Beat carries
//   -------  ----------------------------------  ---------  -----------------------
//   in       in_valid in_ready in_req_type       sink       one request or char
//            in_char_value
//   out      out_valid out_ready out_matched     source     one result per end
//            out_points out_match_kind                      marker
//            out_too_long
//
// Input beats are taken at one beat per clock while the output register is
// free or drained. The two needle read ports are read at the positions the
// next haystack character will need, so the compare for each character uses
// data fetched during the previous beat. A result is registered and appears
// in the cycle after its end marker. Reset (rst_n low, synchronous) empties the
// needle and the haystack state; the needle memory is not cleared. A stalled
// result stalls only the input, and only until the output register is free.
// ============================================================================
`default_nettype none

module fuzzy_subsequence_scorer #(
  parameter int unsigned NEEDLE_MAX = 64,
  parameter int unsigned HAY_MAX    = 1023
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [7:0]  in_char_value,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_matched,
  output logic [10:0]      out_points,
  output logic [1:0]       out_match_kind,
  output logic             out_too_long
);

  // Needle count must hold NEEDLE_MAX itself; the address only an index.
  localparam int unsigned NW = $clog2(NEEDLE_MAX + 1);
  localparam int unsigned AW = (NEEDLE_MAX > 1) ? $clog2(NEEDLE_MAX) : 1;
  localparam int unsigned HW = $clog2(HAY_MAX + 1);
  localparam int unsigned SW = fss_pkg::SCORE_W;
  // Common width for comparing counts and scores.
  localparam int unsigned XW0 = (HW > NW) ? HW : NW;
  localparam int unsigned XW  = (XW0 > SW) ? XW0 : SW;
  localparam int unsigned PW  = HW + 17;

  // --------------------------------------------------------------------------
  // State registers
  // --------------------------------------------------------------------------
  logic [NW-1:0] needle_count_r, needle_count_nxt;
  logic [HW-1:0] hay_count_r,    hay_count_nxt;
  logic          hay_ovf_r,      hay_ovf_nxt;
  logic [NW-1:0] fz_pos_r,       fz_pos_nxt;
  logic [SW-1:0] fz_sum_r,       fz_sum_nxt;
  logic          prev_match_r,   prev_match_nxt;
  logic          prev_bnd_r,     prev_bnd_nxt;
  logic [NW-1:0] ini_pos_r,      ini_pos_nxt;
  logic          ini_fail_r,     ini_fail_nxt;

  logic             out_valid_r, out_valid_nxt;
  fss_pkg::result_t out_res_r,   out_res_nxt;

  // --------------------------------------------------------------------------
  // Needle memory. Port 0 follows the fuzzy position, port 1 the initials
  // position; both are addressed with the next-state positions so that the
  // registered data lines up with the next haystack beat.
  // --------------------------------------------------------------------------
  logic          mem_we;
  logic [7:0]    fz_rd_data;
  logic [7:0]    ini_rd_data;
  logic [7:0]    char_fold;
  logic          char_bnd;

  fss_needle_mem #(
    .DEPTH (NEEDLE_MAX),
    .AW    (AW)
  ) u_needle_mem (
    .clk      (clk),
    .wr_en    (mem_we),
    .wr_addr  (needle_count_r[AW-1:0]),
    .wr_data  (char_fold),
    .rd0_addr (fz_pos_nxt[AW-1:0]),
    .rd0_data (fz_rd_data),
    .rd1_addr (ini_pos_nxt[AW-1:0]),
    .rd1_data (ini_rd_data)
  );

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic in_fire;

  assign in_ready = !out_valid_r || out_ready;
  assign in_fire  = in_valid && in_ready;

  assign char_fold = fss_pkg::fold(in_char_value);
  assign char_bnd  = fss_pkg::is_boundary(in_char_value);

  // --------------------------------------------------------------------------
  // Per-character scan
  // --------------------------------------------------------------------------
  logic          hay_full;
  logic          fz_hit;
  logic [4:0]    pts;
  logic [SW:0]   fz_sum_ext;

  assign hay_full = hay_count_r >= HW'(HAY_MAX);
  assign fz_hit   = (fz_pos_r < needle_count_r) && (fz_rd_data == char_fold);

  always_comb begin
    pts = fss_pkg::PTS_BASE;
    if (prev_bnd_r) begin
      pts = pts + fss_pkg::PTS_WORD;
    end
    if (prev_match_r) begin
      pts = pts + fss_pkg::PTS_CONSEC;
    end
    if (hay_count_r == '0) begin
      pts = pts + fss_pkg::PTS_FIRST;
    end
  end

  assign fz_sum_ext = {1'b0, fz_sum_r} + (SW+1)'(pts);

  // --------------------------------------------------------------------------
  // End-of-haystack result. The length penalty is (hay - needle) / 10 by a
  // reciprocal multiply; needle <= hay holds whenever the penalty is used.
  // --------------------------------------------------------------------------
  logic [HW-1:0] len_diff;
  logic [PW-1:0] pen_prod;
  logic [HW-1:0] pen;
  logic [XW-1:0] nc_x, hc_x, sum_x, pen_x, fz_score_x;
  fss_pkg::result_t res;

  assign len_diff = hay_count_r - HW'(needle_count_r);
  assign pen_prod = PW'(len_diff) * PW'(fss_pkg::DIV10_MUL);
  assign pen      = HW'(pen_prod >> fss_pkg::DIV10_SHIFT);

  assign nc_x  = XW'(needle_count_r);
  assign hc_x  = XW'(hay_count_r);
  assign sum_x = XW'(fz_sum_r);
  assign pen_x = XW'(pen);

  always_comb begin
    fz_score_x = (sum_x > pen_x) ? (sum_x - pen_x) : '0;
    if (fz_score_x < XW'(fss_pkg::SCORE_FLOOR)) begin
      fz_score_x = XW'(fss_pkg::SCORE_FLOOR);
    end
  end

  always_comb begin
    res.matched  = 1'b0;
    res.score    = '0;
    res.kind     = fss_pkg::KIND_NONE;
    res.too_long = hay_ovf_r;
    if (needle_count_r == '0) begin
      res.matched = 1'b1;
      res.score   = fss_pkg::SCORE_EMPTY;
      res.kind    = fss_pkg::KIND_EMPTY;
    end else if (nc_x > hc_x) begin
      res.matched = 1'b0;
    end else if (!ini_fail_r && ini_pos_r == needle_count_r) begin
      res.matched = 1'b1;
      res.score   = fss_pkg::SCORE_INITIALS;
      res.kind    = fss_pkg::KIND_INITIALS;
    end else if (fz_pos_r == needle_count_r) begin
      res.matched = 1'b1;
      res.score   = fz_score_x[SW-1:0];
      res.kind    = fss_pkg::KIND_FUZZY;
    end
  end

  // --------------------------------------------------------------------------
  // Next-state logic
  // --------------------------------------------------------------------------
  always_comb begin
    logic restart;
    restart          = 1'b0;
    mem_we           = 1'b0;
    needle_count_nxt = needle_count_r;
    hay_count_nxt    = hay_count_r;
    hay_ovf_nxt      = hay_ovf_r;
    fz_pos_nxt       = fz_pos_r;
    fz_sum_nxt       = fz_sum_r;
    prev_match_nxt   = prev_match_r;
    prev_bnd_nxt     = prev_bnd_r;
    ini_pos_nxt      = ini_pos_r;
    ini_fail_nxt     = ini_fail_r;
    out_res_nxt      = out_res_r;
    out_valid_nxt    = out_valid_r && !out_ready;

    if (in_fire) begin
      case (in_req_type)
        fss_pkg::REQ_CLEAR: begin
          needle_count_nxt = '0;
          restart          = 1'b1;
        end
        fss_pkg::REQ_NEEDLE: begin
          // Appends past the needle capacity are dropped.
          if (needle_count_r < NW'(NEEDLE_MAX)) begin
            mem_we           = 1'b1;
            needle_count_nxt = needle_count_r + 1'b1;
          end
          restart = 1'b1;
        end
        fss_pkg::REQ_HAY: begin
          if (hay_full) begin
            hay_ovf_nxt = 1'b1;
          end else begin
            if (prev_bnd_r && !char_bnd && !ini_fail_r &&
                ini_pos_r < needle_count_r) begin
              if (ini_rd_data == char_fold) begin
                ini_pos_nxt = ini_pos_r + 1'b1;
              end else begin
                ini_fail_nxt = 1'b1;
              end
            end
            if (fz_hit) begin
              fz_sum_nxt     = fz_sum_ext[SW] ? fss_pkg::SCORE_MAX : fz_sum_ext[SW-1:0];
              fz_pos_nxt     = fz_pos_r + 1'b1;
              prev_match_nxt = 1'b1;
            end else begin
              prev_match_nxt = 1'b0;
            end
            prev_bnd_nxt  = char_bnd;
            hay_count_nxt = hay_count_r + 1'b1;
          end
        end
        fss_pkg::REQ_END: begin
          out_res_nxt   = res;
          out_valid_nxt = 1'b1;
          restart       = 1'b1;
        end
        default: begin
          restart = 1'b0;
        end
      endcase
    end

    if (restart) begin
      hay_count_nxt  = '0;
      hay_ovf_nxt    = 1'b0;
      fz_pos_nxt     = '0;
      fz_sum_nxt     = '0;
      prev_match_nxt = 1'b0;
      prev_bnd_nxt   = 1'b1;
      ini_pos_nxt    = '0;
      ini_fail_nxt   = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      needle_count_r <= '0;
      hay_count_r    <= '0;
      hay_ovf_r      <= 1'b0;
      fz_pos_r       <= '0;
      fz_sum_r       <= '0;
      prev_match_r   <= 1'b0;
      prev_bnd_r     <= 1'b1;
      ini_pos_r      <= '0;
      ini_fail_r     <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      needle_count_r <= needle_count_nxt;
      hay_count_r    <= hay_count_nxt;
      hay_ovf_r      <= hay_ovf_nxt;
      fz_pos_r       <= fz_pos_nxt;
      fz_sum_r       <= fz_sum_nxt;
      prev_match_r   <= prev_match_nxt;
      prev_bnd_r     <= prev_bnd_nxt;
      ini_pos_r      <= ini_pos_nxt;
      ini_fail_r     <= ini_fail_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // The result payload needs no reset.
  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_matched    = out_res_r.matched;
  assign out_points     = out_res_r.score;
  assign out_match_kind = out_res_r.kind;
  assign out_too_long   = out_res_r.too_long;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fz_pos_bound : assert property (@(posedge clk) disable iff (!rst_n)
    fz_pos_r <= needle_count_r)
    else $error("fuzzy position ran past the needle length");

  a_ini_pos_bound : assert property (@(posedge clk) disable iff (!rst_n)
    ini_pos_r <= needle_count_r)
    else $error("initials position ran past the needle length");

  a_needle_bound : assert property (@(posedge clk) disable iff (!rst_n)
    needle_count_r <= NW'(NEEDLE_MAX))
    else $error("needle count exceeds capacity");

  a_end_restart : assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_req_type == fss_pkg::REQ_END |=>
      out_valid_r && hay_count_r == '0 && !hay_ovf_r)
    else $error("end marker did not publish a result and restart the scan");

  a_none_is_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_res_r.kind == fss_pkg::KIND_NONE |->
      !out_res_r.matched && out_res_r.score == '0)
    else $error("unmatched result carries a score");

endmodule

`default_nettype wire
